/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("assertion failed");

`endif

/* rtl/core/sgt_pkg.sv */
// Shared types, constants and a helper function of the sequence gap tracker.
`default_nettype none

package sgt_pkg;

   localparam int WINDOW  = 64;
   localparam int ADDR_W  = $clog2(WINDOW);
   localparam int OP_W    = 2;
   localparam int HEAD_W  = 7;
   localparam int SLOT_W  = 6;
   localparam int TOTAL_W = 7;
   localparam int ENTRY_W = 2;

   localparam logic [HEAD_W-1:0] WIN_HEAD = HEAD_W'(WINDOW);

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_LIST   = 2'd2,
      OP_CLOSE  = 2'd3
   } op_type;

   typedef struct packed {
      logic recv;
      logic miss;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      entry_type         ent;
   } wr_req_type;

   function automatic logic [HEAD_W-1:0] head_clamp(input logic [HEAD_W-1:0] v);
      logic [HEAD_W-1:0] r;
      r = (v > WIN_HEAD) ? WIN_HEAD : v;
      return r;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/sgt_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module sgt_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/sgt_store.sv */
// Slot store: the per-slot received and missing bits in RAM, with valid bits for reset.
`default_nettype none

module sgt_store (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sgt_pkg::rd_req_type rd_req,
   input  wire sgt_pkg::wr_req_type wr_req,
   output      sgt_pkg::entry_type  rd_ent
);

   import sgt_pkg::*;

   logic [WINDOW-1:0]  vld_ff;
   logic               rd_vld_ff;
   logic [ENTRY_W-1:0] ram_q;

   sgt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(WINDOW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_req.en),
      .wr_addr (wr_req.addr),
      .wr_data (wr_req.ent),
      .rd_en   (rd_req.en),
      .rd_addr (rd_req.addr),
      .rd_data (ram_q)
   );

   // An entry never written since reset reads as neither received nor missing.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_req.en) begin
            vld_ff[wr_req.addr] <= 1'b1;
         end
         if (rd_req.en) begin
            rd_vld_ff <= vld_ff[rd_req.addr];
         end
      end
   end

   assign rd_ent = rd_vld_ff ? entry_type'(ram_q) : '0;

endmodule

`default_nettype wire

/* rtl/core/sequence_gap_tracker.sv */
// Top level of the sequence gap tracker: command decode, slot walks and result register.
//
// The tracker keeps, for each of WINDOW sequence slots, a received bit and a
// missing bit in a single RAM, plus a scan head and a running count of missing
// slots in registers. A command is taken when start is high and busy is low.
// Insert and query first read the slot, then decide; an insert also writes
// the slot back. An insert above the head also walks the skipped slots, one
// per cycle. Close walks from the head to the top of the window. A listing
// with nothing missing answers without a walk; otherwise it walks the window
// from slot 0 and stops at the last missing slot. The single RAM read port
// sets the pace of every walk. Each result is shown for exactly one cycle
// with rsp_valid high; there is no backpressure, so the receiver must take
// every result in the cycle it appears. A write on the csr port loads the
// head at once and must only be made while busy is low.
`default_nettype none

module sequence_gap_tracker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output      logic                        busy,
   input  wire logic [sgt_pkg::OP_W-1:0]    req_op,
   input  wire logic [sgt_pkg::HEAD_W-1:0]  req_pos,
   input  wire logic                        csr_wr_en,
   input  wire logic [sgt_pkg::HEAD_W-1:0]  csr_wr_data,
   output      logic                        rsp_valid,
   output      logic                        rsp_status,
   output      logic                        rsp_present,
   output      logic [sgt_pkg::SLOT_W-1:0]  rsp_missing_slot,
   output      logic                        rsp_none_missing,
   output      logic [sgt_pkg::TOTAL_W-1:0] rsp_missing_total,
   output      logic                        rsp_last
);

   import sgt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FILL,
      ST_SCAN
   } state_type;

   typedef struct packed {
      logic               status;
      logic               present;
      logic [SLOT_W-1:0]  slot;
      logic               none;
      logic [TOTAL_W-1:0] total;
      logic               last;
   } rsp_type;

   state_type          state_ff,  state_in;
   logic [HEAD_W-1:0]  head_ff,   head_in;
   logic [TOTAL_W-1:0] count_ff,  count_in;
   op_type             op_ff,     op_in;
   logic [HEAD_W-1:0]  pos_ff,    pos_in;
   logic [HEAD_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [HEAD_W-1:0]  end_ff,    end_in;
   logic               pend_ff,   pend_in;
   logic [ADDR_W-1:0]  wr_idx_ff, wr_idx_in;
   logic [TOTAL_W-1:0] emit_ff,   emit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff,    rsp_in;

   rd_req_type rd_req;
   wr_req_type wr_req;
   entry_type  rd_ent;

   logic last_hit;

   sgt_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_req (rd_req),
      .wr_req (wr_req),
      .rd_ent (rd_ent)
   );

   assign last_hit = ((emit_ff + TOTAL_W'(1)) == count_ff);

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      rd_idx_in    = rd_idx_ff;
      end_in       = end_ff;
      pend_in      = pend_ff;
      wr_idx_in    = wr_idx_ff;
      emit_in      = emit_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_req       = '0;
      wr_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in  = op_type'(req_op);
               pos_in = req_pos;
               case (op_type'(req_op))
                  OP_INSERT, OP_QUERY: begin
                     rd_req.en   = 1'b1;
                     rd_req.addr = req_pos[ADDR_W-1:0];
                     state_in    = ST_EVAL;
                  end
                  OP_LIST: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = '0;
                        rsp_in.none  = 1'b1;
                        rsp_in.last  = 1'b1;
                     end else begin
                        rd_idx_in = '0;
                        pend_in   = 1'b0;
                        emit_in   = '0;
                        state_in  = ST_SCAN;
                     end
                  end
                  OP_CLOSE: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                     rsp_in.last  = 1'b1;
                     rd_idx_in    = head_ff;
                     end_in       = WIN_HEAD;
                     pend_in      = 1'b0;
                     head_in      = WIN_HEAD;
                     state_in     = ST_FILL;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_EVAL: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '0;
            rsp_in.last  = 1'b1;
            state_in     = ST_IDLE;
            if (op_ff == OP_QUERY) begin
               rsp_in.present = (pos_ff < WIN_HEAD) && rd_ent.recv;
               rsp_in.status  = !rsp_in.present;
            end else if ((pos_ff >= WIN_HEAD) || rd_ent.recv) begin
               rsp_in.status = 1'b1;
            end else begin
               wr_req.en       = 1'b1;
               wr_req.addr     = pos_ff[ADDR_W-1:0];
               wr_req.ent.recv = 1'b1;
               if (pos_ff < head_ff) begin
                  wr_req.ent.miss = 1'b0;
                  if (rd_ent.miss) begin
                     count_in = count_ff - TOTAL_W'(1);
                  end
               end else begin
                  wr_req.ent.miss = rd_ent.miss;
                  head_in         = pos_ff + HEAD_W'(1);
                  if (pos_ff > head_ff) begin
                     rd_idx_in = head_ff;
                     end_in    = pos_ff;
                     pend_in   = 1'b0;
                     state_in  = ST_FILL;
                  end
               end
            end
         end

         ST_FILL: begin
            if (pend_ff && !rd_ent.recv) begin
               wr_req.en       = 1'b1;
               wr_req.addr     = wr_idx_ff;
               wr_req.ent.recv = 1'b0;
               wr_req.ent.miss = 1'b1;
               if (!rd_ent.miss) begin
                  count_in = count_ff + TOTAL_W'(1);
               end
            end
            if (rd_idx_ff < end_ff) begin
               rd_req.en   = 1'b1;
               rd_req.addr = rd_idx_ff[ADDR_W-1:0];
               pend_in     = 1'b1;
               wr_idx_in   = rd_idx_ff[ADDR_W-1:0];
               rd_idx_in   = rd_idx_ff + HEAD_W'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            if (rd_idx_ff < WIN_HEAD) begin
               rd_req.en   = 1'b1;
               rd_req.addr = rd_idx_ff[ADDR_W-1:0];
               pend_in     = 1'b1;
               wr_idx_in   = rd_idx_ff[ADDR_W-1:0];
               rd_idx_in   = rd_idx_ff + HEAD_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && rd_ent.miss) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.slot  = SLOT_W'(wr_idx_ff);
               rsp_in.total = count_ff;
               rsp_in.last  = last_hit;
               emit_in      = emit_ff + TOTAL_W'(1);
               if (last_hit) begin
                  pend_in  = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         head_in = head_clamp(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      pos_ff    <= pos_in;
      rd_idx_ff <= rd_idx_in;
      end_ff    <= end_in;
      wr_idx_ff <= wr_idx_in;
      emit_ff   <= emit_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= head_clamp('0);
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_present       = rsp_ff.present;
   assign rsp_missing_slot  = rsp_ff.slot;
   assign rsp_none_missing  = rsp_ff.none;
   assign rsp_missing_total = rsp_ff.total;
   assign rsp_last          = rsp_ff.last;

endmodule

`default_nettype wire

/* rtl/core/sgt_checker.sv */
// Port-level assertions for the sequence gap tracker and their bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module sgt_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic [sgt_pkg::OP_W-1:0]    req_op,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_status,
   input wire logic                        rsp_present,
   input wire logic                        rsp_none_missing,
   input wire logic [sgt_pkg::TOTAL_W-1:0] rsp_missing_total,
   input wire logic                        rsp_last
);

   import sgt_pkg::*;

   logic single_op;
   logic list_empty;
   logic rsp_reject;

   assign single_op = start && !busy && (req_op == OP_INSERT || req_op == OP_QUERY);
   assign list_empty = rsp_valid && rsp_none_missing;
   assign rsp_reject = rsp_valid && rsp_status;

   `ASSERT_NEXT(a_single_busy, clock, reset, single_op, busy)
   `ASSERT_IMPLY(a_single_answer, clock, reset, single_op, ##2 (rsp_valid && rsp_last))
   `ASSERT_IMPLY(a_more_follow, clock, reset, rsp_valid && !rsp_last, busy)
   `ASSERT_IMPLY(a_empty_list, clock, reset, list_empty, (rsp_last && rsp_missing_total == '0))
   `ASSERT_IMPLY(a_reject_alone, clock, reset, rsp_reject, (rsp_last && !rsp_present))

endmodule

bind sequence_gap_tracker sgt_checker u_sgt_checker (.*);

`default_nettype wire
